FILE: design/c_escape_decoder_unit_defines.svh
// assertion macros shared by the checker
`ifndef C_ESCAPE_DECODER_UNIT_DEFINES_SVH
`define C_ESCAPE_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define CED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ced_pkg.sv
`default_nettype none

package ced_pkg;

  // escape letters and special characters
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChN         = 8'h6E;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChDquote    = 8'h22;

  // control bytes produced by escapes
  localparam logic [7:0] CtlTab = 8'h09;
  localparam logic [7:0] CtlLf  = 8'h0A;
  localparam logic [7:0] CtlCr  = 8'h0D;
  localparam logic [7:0] CtlFf  = 8'h0C;
  localparam logic [7:0] CtlBs  = 8'h08;

  // upper five bits shared by '0'..'7'
  localparam logic [4:0] OctHigh = 5'b00110;

  // digit count at which an octal run closes
  localparam logic [1:0] OctMaxDigits = 2'd3;

  // result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

FILE: design/c_escape_decoder_unit.sv
// channel | signals                                      | direction
// --------+----------------------------------------------+----------
// in      | in_valid_i, in_ready_o, in_byte_i, in_last_i | to block
// out     | out_valid_o, out_ready_i, out_byte_o, run_last_o | from block
//
// one input byte is accepted per cycle while the result queue has two free slots
// each byte is decoded in the cycle of its transfer and yields zero to two results,
// which land in a four-entry queue; results leave at one per cycle while out_ready_i is high
// a byte that closes an octal run and is itself emitted yields two results,
// so the output port sets the rate for such bytes
// asynchronous active-low reset returns the decoder to normal mode with an empty queue
// an output stall holds the head result; input stalls only once the queue is nearly full
`default_nettype none

module c_escape_decoder_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic [7:0] out_byte_o,
  output      logic       run_last_o
);

  typedef enum logic [1:0] {
    ModeNormal,
    ModeEscape,
    ModeOctal
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [7:0] oct_val_q, oct_val_d;
  logic [1:0] oct_cnt_q, oct_cnt_d;

  // decode outputs for the byte on the input port
  logic [7:0] res0, res1;
  logic [1:0] nres;
  logic       is_oct;
  logic       in_xfer, out_xfer;

  // result queue
  ced_pkg::res_t                   q_mem [ced_pkg::QDepth];
  logic [ced_pkg::QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [ced_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic [ced_pkg::QPtrW-1:0]       wr_ptr_p1;

  assign in_xfer  = in_valid_i & in_ready_o;
  assign out_xfer = out_valid_o & out_ready_i;
  assign is_oct   = (in_byte_i[7:3] == ced_pkg::OctHigh);

  // room for the worst case of two results
  assign in_ready_o  = (cnt_q <= ced_pkg::QCntW'(ced_pkg::QDepth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_byte_o  = q_mem[rd_ptr_q].data;
  assign run_last_o  = q_mem[rd_ptr_q].last;

  // byte decode and state update
  always_comb begin
    mode_d    = mode_q;
    oct_val_d = oct_val_q;
    oct_cnt_d = oct_cnt_q;
    res0      = 8'h00;
    res1      = 8'h00;
    nres      = 2'd0;

    unique case (mode_q)
      ModeEscape: begin
        mode_d = ModeNormal;
        nres   = 2'd1;
        case (in_byte_i)
          ced_pkg::ChT:         res0 = ced_pkg::CtlTab;
          ced_pkg::ChN:         res0 = ced_pkg::CtlLf;
          ced_pkg::ChR:         res0 = ced_pkg::CtlCr;
          ced_pkg::ChF:         res0 = ced_pkg::CtlFf;
          ced_pkg::ChB:         res0 = ced_pkg::CtlBs;
          ced_pkg::ChBackslash: res0 = ced_pkg::ChBackslash;
          ced_pkg::ChSquote:    res0 = ced_pkg::ChSquote;
          ced_pkg::ChDquote:    res0 = ced_pkg::ChDquote;
          default: begin
            nres = 2'd0;
            if (is_oct) begin
              oct_val_d = {5'b0, in_byte_i[2:0]};
              oct_cnt_d = 2'd1;
              if (in_last_i) begin
                res0 = {5'b0, in_byte_i[2:0]};
                nres = 2'd1;
              end else begin
                mode_d = ModeOctal;
              end
            end
          end
        endcase
      end
      ModeOctal: begin
        if (is_oct) begin
          oct_val_d = {oct_val_q[4:0], in_byte_i[2:0]};
          oct_cnt_d = oct_cnt_q + 2'd1;
          if ((oct_cnt_d == ced_pkg::OctMaxDigits) || in_last_i) begin
            res0   = oct_val_d;
            nres   = 2'd1;
            mode_d = ModeNormal;
          end
        end else begin
          // flush the pending value, then treat the byte as plain
          res0   = oct_val_q;
          nres   = 2'd1;
          mode_d = ModeNormal;
          if (in_byte_i == ced_pkg::ChBackslash) begin
            if (!in_last_i) mode_d = ModeEscape;
          end else begin
            res1 = in_byte_i;
            nres = 2'd2;
          end
        end
      end
      default: begin
        mode_d = ModeNormal;
        if (in_byte_i == ced_pkg::ChBackslash) begin
          if (!in_last_i) mode_d = ModeEscape;
        end else begin
          res0 = in_byte_i;
          nres = 2'd1;
        end
      end
    endcase

    if (mode_d != ModeOctal) begin
      oct_val_d = 8'h00;
      oct_cnt_d = 2'd0;
    end
    // end of string always leaves a clean state
    if (in_last_i) begin
      mode_d    = ModeNormal;
      oct_val_d = 8'h00;
      oct_cnt_d = 2'd0;
    end
  end

  assign wr_ptr_p1 = wr_ptr_q + ced_pkg::QPtrW'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer)  cnt_d = cnt_d + ced_pkg::QCntW'(nres);
    if (out_xfer) cnt_d = cnt_d - ced_pkg::QCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeNormal;
      oct_val_q <= 8'h00;
      oct_cnt_q <= 2'd0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      cnt_q     <= '0;
    end else begin
      if (in_xfer) begin
        mode_q    <= mode_d;
        oct_val_q <= oct_val_d;
        oct_cnt_q <= oct_cnt_d;
        wr_ptr_q  <= wr_ptr_q + ced_pkg::QPtrW'(nres);
      end
      if (out_xfer) rd_ptr_q <= rd_ptr_q + ced_pkg::QPtrW'(1);
      cnt_q <= cnt_d;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer && (nres != 2'd0)) begin
      q_mem[wr_ptr_q].data <= res0;
      q_mem[wr_ptr_q].last <= (nres == 2'd1);
    end
    if (in_xfer && (nres == 2'd2)) begin
      q_mem[wr_ptr_p1].data <= res1;
      q_mem[wr_ptr_p1].last <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: design/ced_checker.sv
`default_nettype none
`include "c_escape_decoder_unit_defines.svh"

module ced_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [7:0] in_byte_i,
  input wire logic       in_last_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       run_last_o
);

  logic out_stall;
  logic more_follows;
  logic in_idle_byte;

  assign out_stall    = out_valid_o & ~out_ready_i;
  assign more_follows = out_valid_o & out_ready_i & ~run_last_o;
  // lone backslash offered as the final byte of a string
  assign in_idle_byte = in_valid_i & in_last_i & (in_byte_i == ced_pkg::ChBackslash);

  // a stalled result holds its payload
  `CED_ASSERT_NEXT(a_out_hold, out_stall,
    out_valid_o && $stable(out_byte_o) && $stable(run_last_o), "stalled result changed")

  // a result that is not the last of its byte is followed at once by the next one
  `CED_ASSERT_NEXT(a_pair_follows, more_follows, out_valid_o, "second result missing")

  // with nothing queued the input is open
  `CED_ASSERT_NOW(a_empty_ready, !out_valid_o, in_ready_o, "input closed with empty queue")

  // a final lone backslash is always takeable when the queue is empty
  `CED_ASSERT_NOW(a_last_bs_ready, in_idle_byte && !out_valid_o, in_ready_o,
    "final backslash blocked")

endmodule

bind c_escape_decoder_unit ced_checker u_ced_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_byte_i   (in_byte_i),
  .in_last_i   (in_last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .run_last_o  (run_last_o)
);

`default_nettype wire

FILE: dv/escape_decode_checker.sv
module escape_decode_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       run_last_i,
  output int         mismatch_count_o,
  output int         pending_o
);

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeEscape = 2'd1,
    ModeOctal  = 2'd2
  } decode_mode_e;

  decode_mode_e mode_q;
  logic [7:0]   oct_val;
  logic [1:0]   oct_cnt;

  // decoded bytes of the current input transfer
  logic [7:0]   step_out [2];
  int           step_n;

  ced_pkg::res_t decoded_q [$];
  ced_pkg::res_t want;
  ced_pkg::res_t seen;
  int            mismatches;

  function automatic void emit(input logic [7:0] b);
    if (step_n < 2) begin
      step_out[step_n] = b;
      step_n++;
    end
  endfunction

  function automatic void take_plain(input logic [7:0] b, input logic lst);
    if (b == ced_pkg::ChBackslash) begin
      if (!lst) mode_q = ModeEscape;
    end else begin
      emit(b);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic lst);
    logic is_oct;
    is_oct = (b[7:3] == ced_pkg::OctHigh);
    step_n = 0;
    case (mode_q)
      ModeEscape: begin
        mode_q = ModeNormal;
        case (b)
          ced_pkg::ChT:         emit(ced_pkg::CtlTab);
          ced_pkg::ChN:         emit(ced_pkg::CtlLf);
          ced_pkg::ChR:         emit(ced_pkg::CtlCr);
          ced_pkg::ChF:         emit(ced_pkg::CtlFf);
          ced_pkg::ChB:         emit(ced_pkg::CtlBs);
          ced_pkg::ChBackslash: emit(ced_pkg::ChBackslash);
          ced_pkg::ChSquote:    emit(ced_pkg::ChSquote);
          ced_pkg::ChDquote:    emit(ced_pkg::ChDquote);
          default: begin
            if (is_oct) begin
              oct_val = {5'd0, b[2:0]};
              oct_cnt = 2'd1;
              if (lst) emit(oct_val);
              else mode_q = ModeOctal;
            end
          end
        endcase
      end
      ModeOctal: begin
        if (is_oct) begin
          // shift by three then add, kept modulo 256
          oct_val = {oct_val[4:0], b[2:0]};
          oct_cnt = oct_cnt + 2'd1;
          if (oct_cnt >= ced_pkg::OctMaxDigits || lst) begin
            emit(oct_val);
            mode_q = ModeNormal;
          end
        end else begin
          emit(oct_val);
          mode_q = ModeNormal;
          take_plain(b, lst);
        end
      end
      default: begin
        mode_q = ModeNormal;
        take_plain(b, lst);
      end
    endcase
    if (mode_q != ModeOctal) begin
      oct_val = 8'd0;
      oct_cnt = 2'd0;
    end
    if (lst) begin
      mode_q  = ModeNormal;
      oct_val = 8'd0;
      oct_cnt = 2'd0;
    end
    for (int i = 0; i < step_n; i++) begin
      want.data = step_out[i];
      want.last = (i == step_n - 1);
      decoded_q.insert(decoded_q.size(), want);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     = ModeNormal;
      oct_val    = 8'd0;
      oct_cnt    = 2'd0;
      mismatches = 0;
      decoded_q.delete();
    end else begin
      // predict first so a same-cycle result would still find its entry
      if (in_valid_i && in_ready_i) decode_byte(in_byte_i, in_last_i);
      if (out_valid_i && out_ready_i) begin
        seen.data = out_byte_i;
        seen.last = run_last_i;
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: byte %02h run_last %0b", seen.data, seen.last);
        end else begin
          want = decoded_q.pop_front();
          if (seen.data !== want.data || seen.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected byte %02h run_last %0b, got byte %02h run_last %0b",
                       want.data, want.last, seen.data, seen.last);
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= decoded_q.size();
  end

endmodule

FILE: dv/tb_top.sv
module tb_top;

  // characters used to build escaped strings
  localparam logic [7:0] DigitZero  = 8'h30;
  localparam logic [7:0] DigitEight = 8'h38;
  localparam logic [7:0] DigitNine  = 8'h39;
  localparam logic [7:0] EscChars [8] = '{ced_pkg::ChT, ced_pkg::ChN, ced_pkg::ChR,
                                          ced_pkg::ChF, ced_pkg::ChB,
                                          ced_pkg::ChBackslash, ced_pkg::ChSquote,
                                          ced_pkg::ChDquote};

  // roughly how many input bytes the random part sends
  localparam int RandomBytes = 600;
  // cycles without any transfer before the run is declared hung
  localparam int QuietLimit  = 2000;
  // drain time after the last expected result, well above the queue depth
  localparam int TailCycles  = 20;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i   = 8'h00;
  logic       in_last_i   = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b1;
  logic [7:0] out_byte_o;
  logic       run_last_o;

  int         mismatches;
  int         pending;

  // steady stretches: no gaps on either side
  bit         steady = 1'b0;
  int         sent_bytes = 0;
  int         quiet_cycles = 0;
  int         hold_left = 0;

  // bytes of the string being assembled, last flag goes on the final one
  logic [7:0] text_q [$];

  c_escape_decoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

  // predicts every input transfer and compares every output transfer
  escape_decode_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_byte_i        (in_byte_i),
    .in_last_i        (in_last_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_i       (out_byte_o),
    .run_last_i       (run_last_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always #5 clk_i = ~clk_i;

  // gap length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // output side backpressure, changed only at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni || steady) begin
      out_ready_i <= 1'b1;
      hold_left   <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (out_ready_i && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= pick_gap();
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // hang detection: any transfer on either channel restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // one input transfer; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      // idle with junk on the payload, the block must ignore it
      in_valid_i <= 1'b0;
      in_byte_i  <= 8'($urandom);
      in_last_i  <= 1'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_bytes++;
    @(negedge clk_i);
  endtask

  // send the assembled string, marking its final byte
  task automatic flush_text();
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++) send_byte(text_q[i], i == n - 1);
    text_q.delete();
  endtask

  // append one byte to the string being assembled
  function automatic void add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // one lexical piece of an escaped string, mostly well-formed
  function automatic void add_token();
    int digits;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: add_byte(8'($urandom_range(0, 255)));
      4, 5: begin
        add_byte(ced_pkg::ChBackslash);
        add_byte(EscChars[$urandom_range(0, 7)]);
      end
      6, 7: begin
        // one to four octal digits, sometimes closed by an eight or nine
        add_byte(ced_pkg::ChBackslash);
        digits = $urandom_range(1, 4);
        repeat (digits) add_byte(DigitZero + 8'($urandom_range(0, 7)));
        if ($urandom_range(0, 9) < 3)
          add_byte($urandom_range(0, 1) ? DigitEight : DigitNine);
      end
      8: begin
        // escape of an arbitrary byte, usually an unknown one
        add_byte(ced_pkg::ChBackslash);
        add_byte(8'($urandom_range(0, 255)));
      end
      default: add_byte(8'($urandom_range(8'h20, 8'h7e)));
    endcase
  endfunction

  initial begin
    int tokens;
    int keep;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: every named escape, framed by the byte extremes
    add_byte(8'h00);
    add_str("\\t\\n\\r\\f\\b\\\\\\'\\\"");
    add_byte(8'hFF);
    flush_text();
    // unknown escape on a digit nine
    add_str("\\9");
    flush_text();
    // three digits close the run and wrap past 255, the eight after is plain
    add_str("\\7778");
    flush_text();
    // digit eight ends a one-digit run: two results from the last byte
    add_str("\\18");
    flush_text();
    // pending octal flushed by the end of the string
    add_str("\\5");
    flush_text();
    // lone backslash on the last byte is dropped
    add_str("\\");
    flush_text();

    // random strings, a few of them cut off mid-escape
    while (sent_bytes < RandomBytes) begin
      steady = ($urandom_range(0, 9) == 0);
      tokens = $urandom_range(1, 6);
      repeat (tokens) add_token();
      if ($urandom_range(0, 4) == 0) begin
        keep = $urandom_range(1, text_q.size());
        while (text_q.size() > keep) void'(text_q.pop_back());
      end
      flush_text();
    end
    steady     = 1'b0;
    in_valid_i <= 1'b0;

    // drain, then give stray results a chance to show up
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/ced_pkg.sv
design/c_escape_decoder_unit.sv
design/ced_checker.sv
dv/escape_decode_checker.sv
dv/tb_top.sv
